FILE: design/cfr_pkg.sv
// Shared types, constants and helper functions of the command frame receiver.
package cfr_pkg;

  localparam int unsigned LEN_W      = 10;
  localparam int unsigned INTERVAL_W = 14;
  localparam int unsigned FLAGS_W    = 3;
  localparam int unsigned SUM_W      = 7;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned CHECKED_HEAD = 14;

  localparam logic [7:0] CH_OPEN  = 8'd60;
  localparam logic [7:0] CH_CLOSE = 8'd62;
  localparam logic [7:0] CH_LBRK  = 8'd91;
  localparam logic [7:0] CH_RBRK  = 8'd93;
  localparam int unsigned MIN_FRAME = 12;
  localparam int unsigned CMD_POS   = 10;
  localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL = 14'd1000;
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 24'h53544D;

  localparam int unsigned FLAG_ALL = 0;
  localparam int unsigned FLAG_PRS = 1;
  localparam int unsigned FLAG_HUM = 2;

  localparam logic [63:0] KW_STARTINT = "startint";
  localparam logic [31:0] KW_STOP     = "stop";
  localparam logic [39:0] KW_START    = "start";
  localparam logic [47:0] KW_OFFPOM   = "offpom";
  localparam logic [39:0] KW_ONPOM    = "onpom";
  localparam logic [55:0] KW_OFFWILG  = "offwilg";
  localparam logic [47:0] KW_ONWILG   = "onwilg";
  localparam logic [31:0] KW_ARCH     = "arch";

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LEN_ERR  = 3'd1,
    ST_SUM_ERR  = 3'd2,
    ST_ADDR_ERR = 3'd3,
    ST_DATA_LEN = 3'd4,
    ST_NO_CMD   = 3'd5,
    ST_BAD_CMD  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_STARTINT = 4'd1,
    CMD_STOP     = 4'd2,
    CMD_START    = 4'd3,
    CMD_OFFPOM   = 4'd4,
    CMD_ONPOM    = 4'd5,
    CMD_OFFWILG  = 4'd6,
    CMD_ONWILG   = 4'd7,
    CMD_ARCH     = 4'd8
  } cmd_e;

  typedef struct packed {
    status_e                 status;
    cmd_e                    code;
    logic [INTERVAL_W-1:0]   interval;
    logic [FLAGS_W-1:0]      flags;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic [LEN_W-1:0] len_value(input logic [2:0][7:0] d);
    return LEN_W'(d[0][3:0]) * LEN_W'(100) + LEN_W'(d[1][3:0]) * LEN_W'(10)
         + LEN_W'(d[2][3:0]);
  endfunction

  function automatic logic [SUM_W-1:0] mod100(input logic [8:0] v);
    logic [8:0] r;
    if (v >= 9'd300) begin
      r = v - 9'd300;
    end else if (v >= 9'd200) begin
      r = v - 9'd200;
    end else if (v >= 9'd100) begin
      r = v - 9'd100;
    end else begin
      r = v;
    end
    return r[SUM_W-1:0];
  endfunction

endpackage

FILE: design/cfr_check.sv
// Frame checks and keyword decode at the closing bracket.
module cfr_check #(
  parameter int unsigned MAX_COMMAND_LEN = 256,
  parameter int unsigned POS_W           = 9
) (
  input  logic [2:0][7:0]                          len_digits_i,
  input  logic [15:0]                              last_two_i,
  input  logic [cfr_pkg::ADDR_W-1:0]               receiver_i,
  input  logic [cfr_pkg::ADDR_W-1:0]               own_address_i,
  input  logic [cfr_pkg::SUM_W-1:0]                command_sum_i,
  input  logic [POS_W-1:0]                         flen_i,
  input  logic [cfr_pkg::CHECKED_HEAD-1:0][7:0]    head_i,
  input  logic [cfr_pkg::INTERVAL_W-1:0]           interval_i,
  input  logic [cfr_pkg::FLAGS_W-1:0]              flags_i,
  output cfr_pkg::res_t                            res_o
);

  localparam int unsigned CMP_W =
    ((POS_W > cfr_pkg::LEN_W) ? POS_W : cfr_pkg::LEN_W) + 1;
  localparam int unsigned HW_W = 8 * cfr_pkg::CHECKED_HEAD;

  logic [HW_W-1:0]                  hw;
  logic                             len_ok;
  logic                             sum_digits_ok;
  logic [cfr_pkg::LEN_W-1:0]        len;
  logic [CMP_W-1:0]                 len_ext;
  logic [CMP_W-1:0]                 flen_ext;
  logic [cfr_pkg::SUM_W-1:0]        sum_given;
  logic                             int_digits_ok;
  logic [cfr_pkg::INTERVAL_W-1:0]   int_val;

  always_comb begin
    for (int i = 0; i < cfr_pkg::CHECKED_HEAD; i++) begin
      hw[HW_W-1-8*i -: 8] = head_i[i];
    end
  end

  assign len_ok = cfr_pkg::is_digit(len_digits_i[0]) && cfr_pkg::is_digit(len_digits_i[1])
                  && cfr_pkg::is_digit(len_digits_i[2]);
  assign sum_digits_ok = cfr_pkg::is_digit(last_two_i[15:8])
                         && cfr_pkg::is_digit(last_two_i[7:0]);
  assign len      = cfr_pkg::len_value(len_digits_i);
  assign len_ext  = CMP_W'(len);
  assign flen_ext = CMP_W'(flen_i);
  assign sum_given = cfr_pkg::SUM_W'(last_two_i[11:8]) * cfr_pkg::SUM_W'(10)
                   + cfr_pkg::SUM_W'(last_two_i[3:0]);
  assign int_digits_ok = cfr_pkg::is_digit(head_i[9]) && cfr_pkg::is_digit(head_i[10])
                         && cfr_pkg::is_digit(head_i[11]) && cfr_pkg::is_digit(head_i[12]);
  assign int_val = cfr_pkg::INTERVAL_W'(head_i[9][3:0])  * cfr_pkg::INTERVAL_W'(1000)
                 + cfr_pkg::INTERVAL_W'(head_i[10][3:0]) * cfr_pkg::INTERVAL_W'(100)
                 + cfr_pkg::INTERVAL_W'(head_i[11][3:0]) * cfr_pkg::INTERVAL_W'(10)
                 + cfr_pkg::INTERVAL_W'(head_i[12][3:0]);

  always_comb begin
    res_o.status   = cfr_pkg::ST_OK;
    res_o.code     = cfr_pkg::CMD_NONE;
    res_o.interval = interval_i;
    res_o.flags    = flags_i;
    if (!len_ok) begin
      res_o.status = cfr_pkg::ST_LEN_ERR;
    end else if (!sum_digits_ok) begin
      res_o.status = cfr_pkg::ST_SUM_ERR;
    end else if (receiver_i != own_address_i) begin
      res_o.status = cfr_pkg::ST_ADDR_ERR;
    end else if (len == '0) begin
      res_o.status = (flen_ext != CMP_W'(cfr_pkg::MIN_FRAME)) ? cfr_pkg::ST_DATA_LEN
                                                              : cfr_pkg::ST_NO_CMD;
    end else if (len_ext > CMP_W'(MAX_COMMAND_LEN)) begin
      res_o.status = cfr_pkg::ST_LEN_ERR;
    end else if (flen_ext != CMP_W'(cfr_pkg::MIN_FRAME) + len_ext) begin
      res_o.status = cfr_pkg::ST_LEN_ERR;
    end else if (command_sum_i != sum_given) begin
      res_o.status = cfr_pkg::ST_SUM_ERR;
    end else if (len == cfr_pkg::LEN_W'(14) && hw[HW_W-1 -: 64] == cfr_pkg::KW_STARTINT) begin
      if (head_i[8] != cfr_pkg::CH_LBRK || head_i[13] != cfr_pkg::CH_RBRK
          || !int_digits_ok) begin
        res_o.status = cfr_pkg::ST_BAD_CMD;
      end else begin
        res_o.code     = cfr_pkg::CMD_STARTINT;
        res_o.interval = int_val;
        res_o.flags[cfr_pkg::FLAG_ALL] = 1'b1;
      end
    end else if (len == cfr_pkg::LEN_W'(4) && hw[HW_W-1 -: 32] == cfr_pkg::KW_STOP) begin
      res_o.code = cfr_pkg::CMD_STOP;
      res_o.flags[cfr_pkg::FLAG_ALL] = 1'b0;
    end else if (len == cfr_pkg::LEN_W'(5) && hw[HW_W-1 -: 40] == cfr_pkg::KW_START) begin
      res_o.code     = cfr_pkg::CMD_START;
      res_o.interval = cfr_pkg::DEFAULT_INTERVAL;
      res_o.flags[cfr_pkg::FLAG_ALL] = 1'b1;
    end else if (len == cfr_pkg::LEN_W'(6) && hw[HW_W-1 -: 48] == cfr_pkg::KW_OFFPOM) begin
      res_o.code = cfr_pkg::CMD_OFFPOM;
      res_o.flags[cfr_pkg::FLAG_PRS] = 1'b0;
    end else if (len == cfr_pkg::LEN_W'(5) && hw[HW_W-1 -: 40] == cfr_pkg::KW_ONPOM) begin
      res_o.code     = cfr_pkg::CMD_ONPOM;
      res_o.interval = cfr_pkg::DEFAULT_INTERVAL;
      res_o.flags[cfr_pkg::FLAG_PRS] = 1'b1;
    end else if (len == cfr_pkg::LEN_W'(7) && hw[HW_W-1 -: 56] == cfr_pkg::KW_OFFWILG) begin
      res_o.code = cfr_pkg::CMD_OFFWILG;
      res_o.flags[cfr_pkg::FLAG_HUM] = 1'b0;
    end else if (len == cfr_pkg::LEN_W'(6) && hw[HW_W-1 -: 48] == cfr_pkg::KW_ONWILG) begin
      res_o.code     = cfr_pkg::CMD_ONWILG;
      res_o.interval = cfr_pkg::DEFAULT_INTERVAL;
      res_o.flags[cfr_pkg::FLAG_HUM] = 1'b1;
    end else if (len == cfr_pkg::LEN_W'(4) && hw[HW_W-1 -: 32] == cfr_pkg::KW_ARCH) begin
      res_o.code = cfr_pkg::CMD_ARCH;
      res_o.flags[cfr_pkg::FLAG_ALL] = 1'b0;
    end else begin
      res_o.status = cfr_pkg::ST_BAD_CMD;
    end
  end

endmodule

FILE: design/command_frame_receiver.sv
// Command frame receiver top level: byte framing, field capture and result buffering.
// Takes one received byte per clock cycle while in_stall_o is low, with no gaps needed
// between beats. A frame is '<', three sender bytes, three receiver bytes, three decimal
// length digits, the command, two decimal checksum digits and '>'. The closing '>' of a
// frame of at least twelve positions yields one registered status beat; all checks and the
// keyword decode sit in combinational logic between the state registers and the result
// register. The result register is backed by one skid stage, so input beats keep flowing
// while a result waits; in_stall_o rises only when both hold an undelivered result. The
// own address register may be written at any time the block is idle and resets to "STM".
module command_frame_receiver #(
  parameter int unsigned MAX_COMMAND_LEN    = 256,
  parameter int unsigned FRAME_LIMIT        = 269,
  parameter int unsigned KEPT_COMMAND_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cfr_pkg::ADDR_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        frame_status_o,
  output logic [3:0]                        command_code_o,
  output logic [cfr_pkg::INTERVAL_W-1:0]    interval_value_o,
  output logic                              measure_all_on_o,
  output logic                              pressure_on_o,
  output logic                              humidity_on_o
);

  localparam int unsigned POS_W  = $clog2(FRAME_LIMIT);
  localparam int unsigned CMP_W  =
    ((POS_W > cfr_pkg::LEN_W) ? POS_W : cfr_pkg::LEN_W) + 1;
  localparam int unsigned HEAD_W = $clog2(KEPT_COMMAND_BYTES);

  logic [cfr_pkg::ADDR_W-1:0]      own_address_q;
  logic                            in_frame_q, in_frame_d;
  logic [POS_W-1:0]                pos_q, pos_d;
  logic [cfr_pkg::ADDR_W-1:0]      receiver_q, receiver_d;
  logic [2:0][7:0]                 len_digits_q, len_digits_d;
  logic [cfr_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [15:0]                     last_two_q, last_two_d;
  logic [cfr_pkg::INTERVAL_W-1:0]  interval_q;
  logic [cfr_pkg::FLAGS_W-1:0]     flags_q;
  logic [7:0]                      head_q [KEPT_COMMAND_BYTES];
  logic [cfr_pkg::CHECKED_HEAD-1:0][7:0] head_pk;

  logic                            ov_q, sv_q;
  cfr_pkg::res_t                   od_q, sd_q;
  cfr_pkg::res_t                   chk;

  logic                            accept;
  logic                            res_valid;
  logic                            head_we;
  logic                            out_take;
  logic [CMP_W-1:0]                idx_ext;
  logic [CMP_W-1:0]                k_ext;
  logic [CMP_W-1:0]                pos_inc;
  logic                            len_ok;

  assign in_stall_o = sv_q;
  assign accept     = in_valid_i && !sv_q;
  assign out_take   = ov_q && !out_stall_i;

  assign idx_ext = CMP_W'(pos_q);
  assign k_ext   = idx_ext - CMP_W'(cfr_pkg::CMD_POS);
  assign pos_inc = idx_ext + CMP_W'(1);
  assign len_ok  = cfr_pkg::is_digit(len_digits_q[0]) && cfr_pkg::is_digit(len_digits_q[1])
                   && cfr_pkg::is_digit(len_digits_q[2]);

  always_comb begin
    for (int i = 0; i < cfr_pkg::CHECKED_HEAD; i++) begin
      head_pk[i] = head_q[i];
    end
  end

  cfr_check #(
    .MAX_COMMAND_LEN (MAX_COMMAND_LEN),
    .POS_W           (POS_W)
  ) u_check (
    .len_digits_i  (len_digits_q),
    .last_two_i    (last_two_q),
    .receiver_i    (receiver_q),
    .own_address_i (own_address_q),
    .command_sum_i (sum_q),
    .flen_i        (pos_q),
    .head_i        (head_pk),
    .interval_i    (interval_q),
    .flags_i       (flags_q),
    .res_o         (chk)
  );

  always_comb begin
    in_frame_d   = in_frame_q;
    pos_d        = pos_q;
    receiver_d   = receiver_q;
    len_digits_d = len_digits_q;
    sum_d        = sum_q;
    last_two_d   = last_two_q;
    res_valid    = 1'b0;
    head_we      = 1'b0;
    if (accept) begin
      if (rx_byte_i == cfr_pkg::CH_OPEN) begin
        in_frame_d   = 1'b1;
        pos_d        = POS_W'(1);
        receiver_d   = '0;
        len_digits_d = '0;
        sum_d        = '0;
        last_two_d   = '0;
      end else if (in_frame_q) begin
        if (rx_byte_i == cfr_pkg::CH_CLOSE) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
          res_valid  = (idx_ext >= CMP_W'(cfr_pkg::MIN_FRAME));
        end else begin
          if (idx_ext >= CMP_W'(4) && idx_ext <= CMP_W'(6)) begin
            receiver_d = {receiver_q[15:0], rx_byte_i};
          end else if (idx_ext >= CMP_W'(7) && idx_ext <= CMP_W'(9)) begin
            len_digits_d[pos_q[1:0] - 2'd3] = rx_byte_i;
          end else if (idx_ext >= CMP_W'(cfr_pkg::CMD_POS)) begin
            head_we = (k_ext < CMP_W'(KEPT_COMMAND_BYTES));
            if (len_ok && k_ext < CMP_W'(cfr_pkg::len_value(len_digits_q))) begin
              sum_d = cfr_pkg::mod100({2'b00, sum_q} + {1'b0, rx_byte_i});
            end
          end
          last_two_d = {last_two_q[7:0], rx_byte_i};
          if (pos_inc >= CMP_W'(FRAME_LIMIT)) begin
            in_frame_d = 1'b0;
            pos_d      = '0;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= cfr_pkg::OWN_ADDRESS_RST;
      in_frame_q    <= 1'b0;
      pos_q         <= '0;
      receiver_q    <= '0;
      len_digits_q  <= '0;
      sum_q         <= '0;
      last_two_q    <= '0;
      interval_q    <= '0;
      flags_q       <= '0;
      ov_q          <= 1'b0;
      sv_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_address_q <= cfg_data_i;
      end
      in_frame_q   <= in_frame_d;
      pos_q        <= pos_d;
      receiver_q   <= receiver_d;
      len_digits_q <= len_digits_d;
      sum_q        <= sum_d;
      last_two_q   <= last_two_d;
      if (res_valid) begin
        interval_q <= chk.interval;
        flags_q    <= chk.flags;
      end
      if (sv_q) begin
        if (out_take) begin
          sv_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (!ov_q || out_take) begin
          ov_q <= 1'b1;
        end else begin
          sv_q <= 1'b1;
        end
      end else if (out_take) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (out_take) begin
        od_q <= sd_q;
      end
    end else if (res_valid) begin
      if (!ov_q || out_take) begin
        od_q <= chk;
      end else begin
        sd_q <= chk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[k_ext[HEAD_W-1:0]] <= rx_byte_i;
    end
  end

  assign out_valid_o      = ov_q;
  assign frame_status_o   = od_q.status;
  assign command_code_o   = od_q.code;
  assign interval_value_o = od_q.interval;
  assign measure_all_on_o = od_q.flags[cfr_pkg::FLAG_ALL];
  assign pressure_on_o    = od_q.flags[cfr_pkg::FLAG_PRS];
  assign humidity_on_o    = od_q.flags[cfr_pkg::FLAG_HUM];

endmodule

FILE: design/cfr_checker.sv
// Port-level assertions for the command frame receiver and their binding.
module cfr_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [2:0]                        frame_status_o,
  input  logic [3:0]                        command_code_o,
  input  logic [cfr_pkg::INTERVAL_W-1:0]    interval_value_o,
  input  logic                              measure_all_on_o
);

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(frame_status_o) && $stable(command_code_o)
                                   && $stable(interval_value_o))
    else $error("result changed while stalled");

  a_code_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o != cfr_pkg::ST_OK |-> command_code_o == cfr_pkg::CMD_NONE)
    else $error("command code on a failed frame");

  a_start_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_code_o == cfr_pkg::CMD_START
      |-> interval_value_o == cfr_pkg::DEFAULT_INTERVAL && measure_all_on_o)
    else $error("start did not set interval and measurement flag");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);
